>>> design/cu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cu_pkg;

  localparam int RANK_W   = 32;
  localparam int SET_W    = 6;
  localparam int CHOOSE_W = 5;
  localparam int VALUE_W  = 5;
  localparam int BINOM_W  = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = CFG_IDX_W'(1);

  localparam logic [SET_W-1:0]    SET_SIZE_RST     = SET_W'(8);
  localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RST = CHOOSE_W'(2);

  typedef struct packed {
    logic [SET_W-1:0]    row;
    logic [CHOOSE_W-1:0] col;
  } cu_rom_req_t;

  typedef struct packed {
    logic               lt;
    logic [RANK_W-1:0]  diff;
  } cu_cmp_t;

endpackage

`default_nettype wire

>>> design/cu_binom_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module cu_binom_rom
  import cu_pkg::*;
#(
  parameter int MAX_SET    = 32,
  parameter int MAX_CHOOSE = 16
) (
  input  wire logic               clk,
  input  wire cu_rom_req_t        req,
  output logic [BINOM_W-1:0]      data_r
);

  localparam int ROWS  = MAX_SET + 1;
  localparam int COLS  = MAX_CHOOSE + 1;
  localparam int DEPTH = ROWS * COLS;
  localparam int IDX_W = $clog2(DEPTH);

  typedef logic [BINOM_W-1:0] tab_t [DEPTH];

  // Pascal's triangle, row by row, worked out at elaboration.
  function automatic tab_t build_tab();
    tab_t t;
    for (int a = 0; a < ROWS; a++) begin
      for (int b = 0; b < COLS; b++) begin
        if (b == 0) begin
          t[a*COLS+b] = BINOM_W'(1);
        end else if (a == 0) begin
          t[a*COLS+b] = '0;
        end else begin
          t[a*COLS+b] = t[(a-1)*COLS+b-1] + t[(a-1)*COLS+b];
        end
      end
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  logic [IDX_W-1:0] idx;

  assign idx = IDX_W'(req.row) * IDX_W'(COLS) + IDX_W'(req.col);

  always_ff @(posedge clk) begin
    data_r <= TAB[idx];
  end

endmodule

`default_nettype wire

>>> design/cu_cmp_sub.sv
`timescale 1ns / 1ps
`default_nettype none

module cu_cmp_sub
  import cu_pkg::*;
(
  input  wire logic [RANK_W-1:0]  rank,
  input  wire logic [BINOM_W-1:0] count,
  output cu_cmp_t                 res
);

  logic [RANK_W:0] wide;

  assign wide     = {1'b0, rank} - {1'b0, RANK_W'(count)};
  assign res.lt   = wide[RANK_W];
  assign res.diff = wide[RANK_W-1:0];

endmodule

`default_nettype wire

>>> design/combination_unrank.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Word
// in        in_valid / in_ready     in_rank
// out       out_valid / out_ready   out_element_value, out_is_last, out_out_of_range
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A rank is range-checked first (a binomial table read, then a compare), then each
// candidate value walked takes a binomial table read and a compare and subtract; each word
// given waits in the output state, and a new rank is taken only once the last word is given.
// The binomial table has a single registered read port, which paces the walk.
// Reset restores set_size to 8 and choose_count to 2. A stalled output holds the walk.

module combination_unrank
  import cu_pkg::*;
#(
  parameter int MAX_SET    = 32,
  parameter int MAX_CHOOSE = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [RANK_W-1:0]     in_rank,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_W-1:0]         out_element_value,
  output logic                       out_is_last,
  output logic                       out_out_of_range,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TOTAL = 6'b000010,
    S_RANGE = 6'b000100,
    S_LOOK  = 6'b001000,
    S_CMP   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SET_W-1:0]     n_r;
  logic [CHOOSE_W-1:0]  k_r;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [VALUE_W-1:0]   v_r, v_nxt;
  logic [CHOOSE_W-1:0]  rem_r, rem_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic                 last_r, last_nxt;
  logic                 oor_r, oor_nxt;

  cu_rom_req_t          rom_req;
  logic [BINOM_W-1:0]   rom_data;
  cu_cmp_t              cmp;
  logic                 bad_cfg;
  logic                 at_end;
  logic [SET_W-1:0]     n_less1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= SET_SIZE_RST;
      k_r <= CHOOSE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SET_SIZE) begin
        n_r <= cfg_data;
      end else if (cfg_index == REG_CHOOSE_COUNT) begin
        k_r <= cfg_data[CHOOSE_W-1:0];
      end
    end
  end

  assign bad_cfg = (k_r == '0) || ({1'b0, k_r} > n_r) || (n_r > SET_W'(MAX_SET))
                   || (k_r > CHOOSE_W'(MAX_CHOOSE));
  assign n_less1 = n_r - SET_W'(1);
  assign at_end  = ({1'b0, v_r} >= n_less1);

  always_comb begin
    rom_req = '0;
    if (state_r == S_TOTAL) begin
      rom_req.row = n_r;
      rom_req.col = k_r;
    end else if (state_r == S_LOOK) begin
      rom_req.row = n_less1 - {1'b0, v_r};
      rom_req.col = rem_r;
    end
  end

  cu_binom_rom #(
    .MAX_SET    (MAX_SET),
    .MAX_CHOOSE (MAX_CHOOSE)
  ) u_rom (
    .clk    (clk),
    .req    (rom_req),
    .data_r (rom_data)
  );

  cu_cmp_sub u_cmp (
    .rank  (rank_r),
    .count (rom_data),
    .res   (cmp)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_element_value = val_r;
  assign out_is_last       = last_r;
  assign out_out_of_range  = oor_r;

  always_comb begin
    state_nxt = state_r;
    rank_nxt  = rank_r;
    v_nxt     = v_r;
    rem_nxt   = rem_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    oor_nxt   = oor_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rank_nxt = in_rank;
          if (bad_cfg) begin
            val_nxt   = '0;
            last_nxt  = 1'b1;
            oor_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_TOTAL;
          end
        end
      end
      S_TOTAL: begin
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (!cmp.lt) begin
          val_nxt   = '0;
          last_nxt  = 1'b1;
          oor_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          v_nxt     = '0;
          rem_nxt   = k_r - CHOOSE_W'(1);
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (at_end) begin
          val_nxt   = n_less1[VALUE_W-1:0];
          last_nxt  = (rem_r == '0);
          oor_nxt   = 1'b0;
          v_nxt     = n_less1[VALUE_W-1:0];
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (cmp.lt) begin
          val_nxt   = v_r;
          last_nxt  = (rem_r == '0);
          oor_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else begin
          rank_nxt  = cmp.diff;
          v_nxt     = v_r + VALUE_W'(1);
          state_nxt = S_LOOK;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = rem_r - CHOOSE_W'(1);
            v_nxt     = v_r + VALUE_W'(1);
            state_nxt = S_LOOK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    oor_r  <= oor_nxt;
  end

endmodule

`default_nettype wire
